>>> hdl/tdsf_pkg.sv
package tdsf_pkg;

	localparam int SCREEN_WIDTH  = 800;
	localparam int SCREEN_HEIGHT = 480;
	localparam int FRAC_BITS     = 6;

	localparam int FX_W  = 16;
	localparam int FY_W  = 15;
	localparam int TX_W  = 10;
	localparam int TY_W  = 9;
	localparam int SPAN_W = 12;
	localparam int QUO_W = 28;
	localparam int DIV_STEPS = QUO_W;
	localparam int DCNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] REG_MIN_HOLD   = 3'd0;
	localparam logic [2:0] REG_PRESS_GAP  = 3'd1;
	localparam logic [2:0] REG_LIFT_HOLD  = 3'd2;
	localparam logic [2:0] REG_ALPHA      = 3'd3;
	localparam logic [2:0] REG_JUMP_LIMIT = 3'd4;
	localparam logic [2:0] REG_X_SPAN     = 3'd5;
	localparam logic [2:0] REG_Y_SPAN     = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE         = 2'd0,
		PH_PEND_PRESS   = 2'd1,
		PH_PRESSED      = 2'd2,
		PH_PEND_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_BLEND,
		BK_JUMP,
		BK_COMMIT,
		BK_OUT
	} back_state_t;

	// one classified sample as queued between front and back
	typedef struct packed {
		logic        touched;
		logic        neg_x;
		logic [15:0] mag_x;
		logic        neg_y;
		logic [15:0] mag_y;
		logic [31:0] now;
	} sample_t;

	typedef struct packed {
		logic        pressed;
		logic [9:0]  x;
		logic [8:0]  y;
		logic [1:0]  phase;
		logic        event_flag;
		logic [31:0] press_cnt;
		logic [31:0] noise_cnt;
		logic [31:0] sample_cnt;
	} result_t;

endpackage

>>> hdl/touch_debounce_smoothing_filter.sv
// A request passes the queue, the 28-step scale divider, blend, jump check,
// commit and the output register in turn.
// The back end starts the next request only after the previous result is taken.
// A two-entry queue takes requests while the back end works.
// Reset (arst_n low, asynchronous): phase idle, counters, time marks and
// filter cleared; configuration back to its defaults.
module touch_debounce_smoothing_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // is_touched, sample_x, sample_y, time_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [119:0] m_tdata, // report_pressed, report_x, report_y, phase_now,
	                              // press_event, press_count, noise_count, sample_count
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tdsf_pkg::*;

	logic [15:0] min_hold_q, press_gap_q, lift_hold_q;
	logic [8:0]  alpha_q;
	logic [9:0]  jump_q;
	logic [11:0] xspan_q, yspan_q;
	logic        q_valid, q_pop;
	sample_t     q_data;
	result_t     r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hold_q  <= 16'd30;
			press_gap_q <= 16'd80;
			lift_hold_q <= 16'd40;
			alpha_q     <= 9'd77;
			jump_q      <= 10'd100;
			xspan_q     <= 12'd470;
			yspan_q     <= 12'd265;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_HOLD:   min_hold_q  <= cfg_data;
				REG_PRESS_GAP:  press_gap_q <= cfg_data;
				REG_LIFT_HOLD:  lift_hold_q <= cfg_data;
				REG_ALPHA:      alpha_q     <= cfg_data[8:0];
				REG_JUMP_LIMIT: jump_q      <= cfg_data[9:0];
				REG_X_SPAN:     xspan_q     <= cfg_data[11:0];
				REG_Y_SPAN:     yspan_q     <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	tdsf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[64:0]),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	tdsf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.min_hold(min_hold_q), .press_gap(press_gap_q), .lift_hold(lift_hold_q),
		.alpha(alpha_q), .jump_limit(jump_q), .x_span(xspan_q), .y_span(yspan_q),
		.r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
	);

	assign m_tdata = {1'b0, r.sample_cnt, r.noise_cnt, r.press_cnt, r.event_flag,
		r.phase, r.y, r.x, r.pressed};

	a_rep_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[21:20] == PH_PRESSED) |-> m_tdata[0])
		else $error("pressed phase without press report");
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22] |-> m_tdata[0] && (m_tdata[21:20] == PH_PRESSED))
		else $error("press event outside pressed phase");
	a_xrange: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:1] < 10'(SCREEN_WIDTH))
		else $error("x beyond screen");
endmodule

>>> hdl/tdsf_front.sv
module tdsf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [64:0]      s_tdata,
	output logic             q_valid,
	input  logic             q_pop,
	output tdsf_pkg::sample_t q_data
);
	import tdsf_pkg::*;

	sample_t     smp;
	logic [15:0] rx;
	logic [15:0] ry;
	sample_t     fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign rx = s_tdata[16:1];
	assign ry = s_tdata[32:17];

	// split sign and magnitude for the unsigned divider
	always_comb begin
		smp.touched = s_tdata[0];
		smp.neg_x   = rx[15];
		smp.mag_x   = rx[15] ? (~rx + 16'd1) : rx;
		smp.neg_y   = ry[15];
		smp.mag_y   = ry[15] ? (~ry + 16'd1) : ry;
		smp.now     = s_tdata[64:33];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			fifo_q[wr_ptr_q] <= smp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (s_tvalid && s_tready) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop && q_valid) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'((s_tvalid && s_tready) ? 1 : 0)
				- 2'((q_pop && q_valid) ? 1 : 0);
		end
	end
endmodule

>>> hdl/tdsf_back.sv
module tdsf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  tdsf_pkg::sample_t q_data,
	input  logic [15:0]       min_hold,
	input  logic [15:0]       press_gap,
	input  logic [15:0]       lift_hold,
	input  logic [8:0]        alpha,
	input  logic [9:0]        jump_limit,
	input  logic [11:0]       x_span,
	input  logic [11:0]       y_span,
	output logic              r_valid,
	input  logic              r_ready,
	output tdsf_pkg::result_t r_data
);
	import tdsf_pkg::*;

	back_state_t st_q, st_d;
	sample_t     cur_q;
	phase_t      phase_q;
	logic [31:0] start_q, last_q;
	logic [FX_W-1:0] fx_q;
	logic [FY_W-1:0] fy_q;
	logic [31:0] press_q, noise_q, samp_q;

	// restoring divider, both axes in parallel with a shared step counter
	logic [QUO_W-1:0] dividend_x_q, dividend_y_q;
	logic [SPAN_W:0]  rem_x_q, rem_y_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SPAN_W:0]  tx_rem, ty_rem;
	logic [SPAN_W-1:0] dvx, dvy;
	logic [TX_W-1:0] tx_q;
	logic [TY_W-1:0] ty_q;

	logic [FX_W-1:0] nx_q;
	logic [FY_W-1:0] ny_q;
	logic            snap_q;
	logic [8:0]      a9;
	logic [8:0]      na9;
	logic [FX_W+9:0] bx;
	logic [FY_W+9:0] by;
	logic signed [FX_W:0] dx;
	logic signed [FY_W:0] dy;
	logic [FX_W-1:0]   adx;
	logic [FY_W-1:0]   ady;
	logic [2*FX_W-1:0] sqx;
	logic [2*FY_W-1:0] sqy;
	logic [2*FX_W+1:0] d2;
	logic [2*FX_W-1:0] lim2;
	logic [15:0]       limf;
	logic [31:0] el_start, el_last;
	result_t     res_q;
	logic        rv_q;

	assign dvx = (x_span == '0) ? SPAN_W'(1) : x_span;
	assign dvy = (y_span == '0) ? SPAN_W'(1) : y_span;
	assign tx_rem = {rem_x_q[SPAN_W-1:0], dividend_x_q[QUO_W-1]};
	assign ty_rem = {rem_y_q[SPAN_W-1:0], dividend_y_q[QUO_W-1]};

	assign a9  = (alpha > 9'd256) ? 9'd256 : alpha;
	assign na9 = 9'd256 - a9;
	assign bx  = ((FX_W+10)'(a9) * (FX_W+10)'({tx_q, {FRAC_BITS{1'b0}}})
		+ (FX_W+10)'(na9) * (FX_W+10)'(fx_q)) >> 8;
	assign by  = ((FY_W+10)'(a9) * (FY_W+10)'({ty_q, {FRAC_BITS{1'b0}}})
		+ (FY_W+10)'(na9) * (FY_W+10)'(fy_q)) >> 8;
	assign dx  = $signed({1'b0, nx_q}) - $signed({1'b0, fx_q});
	assign dy  = $signed({1'b0, ny_q}) - $signed({1'b0, fy_q});
	// square the magnitudes so the products keep their full width
	assign adx = dx[FX_W] ? FX_W'(-dx) : FX_W'(dx);
	assign ady = dy[FY_W] ? FY_W'(-dy) : FY_W'(dy);
	assign sqx = adx * adx;
	assign sqy = ady * ady;
	assign d2  = (2*FX_W+2)'(sqx) + (2*FX_W+2)'(sqy);
	assign limf = {jump_limit, {FRAC_BITS{1'b0}}};
	assign lim2 = limf * limf;
	assign el_start = cur_q.now - start_q;
	assign el_last  = cur_q.now - last_q;

	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			BK_IDLE:   if (q_valid && !rv_q) begin
				q_pop = 1'b1;
				st_d  = BK_DIV;
			end
			BK_DIV:    if (dcnt_q == DCNT_W'(DIV_STEPS)) st_d = BK_BLEND;
			BK_BLEND:  st_d = BK_JUMP;
			BK_JUMP:   st_d = BK_COMMIT;
			BK_COMMIT: st_d = BK_OUT;
			BK_OUT:    st_d = BK_IDLE;
			default:   st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else         st_q <= st_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			BK_IDLE: begin
				cur_q        <= q_data;
				dividend_x_q <= QUO_W'(q_data.mag_x) * QUO_W'(SCREEN_WIDTH);
				dividend_y_q <= QUO_W'(q_data.mag_y) * QUO_W'(SCREEN_HEIGHT);
				rem_x_q      <= '0;
				rem_y_q      <= '0;
				dcnt_q       <= '0;
			end
			BK_DIV: begin
				if (dcnt_q != DCNT_W'(DIV_STEPS)) begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (tx_rem >= {1'b0, dvx}) begin
						rem_x_q      <= tx_rem - {1'b0, dvx};
						dividend_x_q <= {dividend_x_q[QUO_W-2:0], 1'b1};
					end else begin
						rem_x_q      <= tx_rem;
						dividend_x_q <= {dividend_x_q[QUO_W-2:0], 1'b0};
					end
					if (ty_rem >= {1'b0, dvy}) begin
						rem_y_q      <= ty_rem - {1'b0, dvy};
						dividend_y_q <= {dividend_y_q[QUO_W-2:0], 1'b1};
					end else begin
						rem_y_q      <= ty_rem;
						dividend_y_q <= {dividend_y_q[QUO_W-2:0], 1'b0};
					end
				end else begin
					// negative truncates to a non-positive value: clamp to zero
					tx_q <= (cur_q.neg_x || dividend_x_q == '0) ? '0 :
						(dividend_x_q > QUO_W'(SCREEN_WIDTH - 1)) ?
						TX_W'(SCREEN_WIDTH - 1) : TX_W'(dividend_x_q);
					ty_q <= (cur_q.neg_y || dividend_y_q == '0) ? '0 :
						(dividend_y_q > QUO_W'(SCREEN_HEIGHT - 1)) ?
						TY_W'(SCREEN_HEIGHT - 1) : TY_W'(dividend_y_q);
				end
			end
			BK_BLEND: begin
				nx_q <= FX_W'(bx);
				ny_q <= FY_W'(by);
			end
			BK_JUMP: snap_q <= (jump_limit != '0) && (d2 > (2*FX_W+2)'(lim2));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			last_q  <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			press_q <= '0;
			noise_q <= '0;
			samp_q  <= '0;
			rv_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			if (rv_q && r_ready) rv_q <= 1'b0;
			if (st_q == BK_COMMIT) begin
				samp_q <= samp_q + 32'd1;
				res_q.event_flag <= 1'b0;
				res_q.pressed    <= 1'b0;
				unique case (phase_q)
					PH_IDLE: if (cur_q.touched) begin
						fx_q    <= {tx_q, {FRAC_BITS{1'b0}}};
						fy_q    <= {ty_q, {FRAC_BITS{1'b0}}};
						phase_q <= PH_PEND_PRESS;
						start_q <= cur_q.now;
					end
					PH_PEND_PRESS: if (!cur_q.touched) begin
						phase_q <= PH_IDLE;
						start_q <= cur_q.now;
						noise_q <= noise_q + 32'd1;
					end else begin
						fx_q <= nx_q;
						fy_q <= ny_q;
						if (el_start >= 32'(min_hold)) begin
							if (el_last >= 32'(press_gap)) begin
								phase_q <= PH_PRESSED;
								start_q <= cur_q.now;
								last_q  <= cur_q.now;
								press_q <= press_q + 32'd1;
								res_q.pressed    <= 1'b1;
								res_q.event_flag <= 1'b1;
							end else begin
								phase_q <= PH_IDLE;
								noise_q <= noise_q + 32'd1;
							end
						end
					end
					PH_PRESSED: begin
						res_q.pressed <= 1'b1;
						if (!cur_q.touched) begin
							phase_q <= PH_PEND_RELEASE;
							start_q <= cur_q.now;
						end else if (snap_q) begin
							fx_q <= {tx_q, {FRAC_BITS{1'b0}}};
							fy_q <= {ty_q, {FRAC_BITS{1'b0}}};
						end else begin
							fx_q <= (nx_q > FX_W'((SCREEN_WIDTH-1) << FRAC_BITS)) ?
								FX_W'((SCREEN_WIDTH-1) << FRAC_BITS) : nx_q;
							fy_q <= (ny_q > FY_W'((SCREEN_HEIGHT-1) << FRAC_BITS)) ?
								FY_W'((SCREEN_HEIGHT-1) << FRAC_BITS) : ny_q;
						end
					end
					PH_PEND_RELEASE: if (cur_q.touched) begin
						phase_q <= PH_PRESSED;
						start_q <= cur_q.now;
						fx_q    <= nx_q;
						fy_q    <= ny_q;
						res_q.pressed <= 1'b1;
					end else if (el_start >= 32'(lift_hold)) begin
						phase_q <= PH_IDLE;
						start_q <= cur_q.now;
					end else begin
						res_q.pressed <= 1'b1;
					end
					default: ;
				endcase
			end
			if (st_q == BK_OUT) begin
				res_q.x          <= TX_W'(fx_q >> FRAC_BITS);
				res_q.y          <= TY_W'(fy_q >> FRAC_BITS);
				res_q.phase      <= phase_q;
				res_q.press_cnt  <= press_q;
				res_q.noise_cnt  <= noise_q;
				res_q.sample_cnt <= samp_q;
				rv_q             <= 1'b1;
			end
		end
	end

	assign r_valid = rv_q;
	assign r_data  = res_q;
endmodule

>>> tb/tb_touch_debounce_smoothing_filter.sv
module tb_touch_debounce_smoothing_filter;
	import tdsf_pkg::*;

	typedef struct {
		bit          touch;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [31:0] t;
	} touch_req_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;   // is_touched, sample_x, sample_y, time_ms
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;        // report_pressed, report_x, report_y, phase_now,
	                              // press_event, press_count, noise_count, sample_count
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = REG_MIN_HOLD;
	logic [15:0]  cfg_data = '0;

	touch_req_t  pending_reqs[$];
	result_t     expected_reports[$];
	int          errors = 0;

	// predictor configuration and state
	logic [15:0] p_min_hold, p_press_gap, p_lift_hold;
	logic [8:0]  p_alpha;
	logic [9:0]  p_jump;
	logic [11:0] p_x_span, p_y_span;
	phase_t      p_phase;
	logic [31:0] p_start, p_confirm, p_fx, p_fy, p_presses, p_noises, p_samples;
	logic [31:0] sim_now;

	bit          in_fire = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          long_left = 0;
	bit          long_go = 1'b0;
	bit          long_ack = 1'b0;

	touch_debounce_smoothing_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] scale_to_screen(logic signed [15:0] raw,
			logic [11:0] span, int size);
		longint r;
		longint s;
		longint q;
		r = raw;
		s = (span == 0) ? 1 : span;
		q = (r * size) / s;
		if (q < 0) q = 0;
		if (q > size - 1) q = size - 1;
		return q[31:0];
	endfunction

	function automatic logic [31:0] smooth_towards(logic [31:0] target, logic [31:0] old);
		longint unsigned a;
		longint unsigned tf;
		a = (p_alpha > 256) ? 256 : p_alpha;
		tf = longint'(target) << FRAC_BITS;
		return 32'((a * tf + (256 - a) * longint'(old)) >> 8);
	endfunction

	function automatic logic [31:0] clamp_to_screen(logic [31:0] v, int size);
		logic [31:0] top;
		top = (size - 1) << FRAC_BITS;
		return (v > top) ? top : v;
	endfunction

	function automatic result_t predict_report(touch_req_t r);
		result_t     res;
		logic [31:0] tx, ty, nx, ny;
		longint      dx, dy;
		longint unsigned d2, lim;
		tx = scale_to_screen(r.sx, p_x_span, SCREEN_WIDTH);
		ty = scale_to_screen(r.sy, p_y_span, SCREEN_HEIGHT);
		res = '0;
		p_samples++;
		case (p_phase)
			PH_IDLE: begin
				if (r.touch) begin
					p_fx = tx << FRAC_BITS;
					p_fy = ty << FRAC_BITS;
					p_phase = PH_PEND_PRESS;
					p_start = r.t;
				end
			end
			PH_PEND_PRESS: begin
				if (!r.touch) begin
					p_phase = PH_IDLE;
					p_start = r.t;
					p_noises++;
				end else begin
					p_fx = smooth_towards(tx, p_fx);
					p_fy = smooth_towards(ty, p_fy);
					if (32'(r.t - p_start) >= p_min_hold) begin
						if (32'(r.t - p_confirm) >= p_press_gap) begin
							p_phase = PH_PRESSED;
							p_start = r.t;
							p_confirm = r.t;
							p_presses++;
							res.pressed = 1'b1;
							res.event_flag = 1'b1;
						end else begin
							p_phase = PH_IDLE;
							p_noises++;
						end
					end
				end
			end
			PH_PRESSED: begin
				if (!r.touch) begin
					p_phase = PH_PEND_RELEASE;
					p_start = r.t;
				end else begin
					nx = smooth_towards(tx, p_fx);
					ny = smooth_towards(ty, p_fy);
					if (p_jump != 0) begin
						dx = longint'(nx) - longint'(p_fx);
						dy = longint'(ny) - longint'(p_fy);
						d2 = dx * dx + dy * dy;
						lim = longint'(p_jump) << FRAC_BITS;
						if (d2 > lim * lim) begin
							nx = tx << FRAC_BITS;
							ny = ty << FRAC_BITS;
						end
					end
					p_fx = clamp_to_screen(nx, SCREEN_WIDTH);
					p_fy = clamp_to_screen(ny, SCREEN_HEIGHT);
				end
				res.pressed = 1'b1;
			end
			default: begin
				if (r.touch) begin
					p_phase = PH_PRESSED;
					p_start = r.t;
					p_fx = smooth_towards(tx, p_fx);
					p_fy = smooth_towards(ty, p_fy);
					res.pressed = 1'b1;
				end else if (32'(r.t - p_start) >= p_lift_hold) begin
					p_phase = PH_IDLE;
					p_start = r.t;
				end else begin
					res.pressed = 1'b1;
				end
			end
		endcase
		res.x = p_fx[FRAC_BITS +: 10];
		res.y = p_fy[FRAC_BITS +: 9];
		res.phase = p_phase;
		res.press_cnt = p_presses;
		res.noise_cnt = p_noises;
		res.sample_cnt = p_samples;
		return res;
	endfunction

	task automatic send_sample(bit touch, logic [15:0] sx, logic [15:0] sy, logic [31:0] t);
		touch_req_t r;
		r.touch = touch;
		r.sx = sx;
		r.sy = sy;
		r.t = t;
		expected_reports.push_back(predict_report(r));
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MIN_HOLD:   p_min_hold = val;
			REG_PRESS_GAP:  p_press_gap = val;
			REG_LIFT_HOLD:  p_lift_hold = val;
			REG_ALPHA:      p_alpha = val[8:0];
			REG_JUMP_LIMIT: p_jump = val[9:0];
			REG_X_SPAN:     p_x_span = val[11:0];
			default:        p_y_span = val[11:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (pending_reqs.size() == 0 && expected_reports.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	// random raw coordinate: mostly on screen around a drifting point
	function automatic logic [15:0] raw_coord(logic [11:0] span, int centre);
		int v;
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		v = centre + $urandom_range(0, 60) - 30;
		if ($urandom_range(0, 7) == 0) v = $urandom_range(0, span + span / 8 + 2);
		return 16'(v);
	endfunction

	task automatic random_samples(int count);
		int cx, cy, run, hold, step;
		bit touch;
		touch = 1'b0;
		run = 0;
		cx = $urandom_range(0, p_x_span);
		cy = $urandom_range(0, p_y_span);
		for (int i = 0; i < count; i++) begin
			if (run == 0) begin
				touch = ~touch;
				run = touch ? $urandom_range(1, 30) : $urandom_range(1, 12);
				if (touch) begin
					cx = $urandom_range(0, p_x_span);
					cy = $urandom_range(0, p_y_span);
				end
			end
			run--;
			hold = p_min_hold > p_lift_hold ? p_min_hold : p_lift_hold;
			case ($urandom_range(0, 19))
				0:       step = $urandom;
				1:       step = 0;
				default: step = $urandom_range(0, hold / 8 + 8);
			endcase
			sim_now += 32'(step);
			if ($urandom_range(0, 12) == 0) begin
				cx += $urandom_range(0, 400) - 200;
				cy += $urandom_range(0, 400) - 200;
			end
			send_sample($urandom_range(0, 24) == 0 ? ~touch : touch,
				raw_coord(p_x_span, cx), raw_coord(p_y_span, cy), sim_now);
		end
	endtask

	// sender: bursts with gaps
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				touch_req_t r;
				r = pending_reqs.pop_front();
				s_tdata <= {7'd0, r.t, r.sy, r.sx, r.touch};
				s_tvalid <= 1'b1;
				burst_left--;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: own stall pattern plus an occasional long hold-off
	always @(negedge clk) begin
		if (long_go != long_ack) begin
			long_ack <= long_go;
			long_left = 400;
		end
		if (long_left > 0) begin
			long_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 50);
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			result_t got, want;
			got.pressed    = m_tdata[0];
			got.x          = m_tdata[10:1];
			got.y          = m_tdata[19:11];
			got.phase      = m_tdata[21:20];
			got.event_flag = m_tdata[22];
			got.press_cnt  = m_tdata[54:23];
			got.noise_cnt  = m_tdata[86:55];
			got.sample_cnt = m_tdata[118:87];
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				if (got !== want) begin
					$display("%0t: report mismatch expected %p actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("touch_debounce_smoothing_filter test failed");
		$finish;
	end

	initial begin
		p_min_hold = 30; p_press_gap = 80; p_lift_hold = 40;
		p_alpha = 77; p_jump = 100; p_x_span = 470; p_y_span = 265;
		p_phase = PH_IDLE;
		p_start = '0; p_confirm = '0; p_fx = '0; p_fy = '0;
		p_presses = '0; p_noises = '0; p_samples = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, a full press and release, a jump, wrap
		send_sample(1'b0, 16'h8000, 16'h7fff, 32'd0);
		send_sample(1'b1, 16'h8000, 16'h8000, 32'd5);
		send_sample(1'b1, 16'h7fff, 16'h7fff, 32'd20);
		send_sample(1'b1, 16'd0, 16'd0, 32'd100);
		send_sample(1'b1, 16'd469, 16'd264, 32'd110);
		send_sample(1'b1, 16'd10, 16'd10, 32'd120);
		send_sample(1'b1, 16'd12, 16'd11, 32'd125);
		send_sample(1'b0, 16'd12, 16'd11, 32'd130);
		send_sample(1'b0, 16'd12, 16'd11, 32'd150);
		send_sample(1'b1, 16'd200, 16'd100, 32'd160);
		send_sample(1'b0, 16'd200, 16'd100, 32'd170);
		send_sample(1'b0, 16'd200, 16'd100, 32'd215);
		send_sample(1'b1, 16'd300, 16'd150, 32'd220);
		send_sample(1'b1, 16'd300, 16'd150, 32'd260);
		send_sample(1'b1, 16'd100, 16'd50, 32'hffff_fff0);
		send_sample(1'b1, 16'd100, 16'd50, 32'h0000_0020);
		send_sample(1'b0, 16'd100, 16'd50, 32'h0000_0030);
		send_sample(1'b1, 16'd100, 16'd50, 32'h0000_0031);
		send_sample(1'b1, 16'hfff0, 16'd5000, 32'h0000_0032);
		sim_now = 32'h0000_0100;
		long_go = ~long_go;
		random_samples(260);
		wait_drained();

		for (int ph = 1; ph <= 5; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_MIN_HOLD, 0); write_reg(REG_PRESS_GAP, 0);
					write_reg(REG_LIFT_HOLD, 0); write_reg(REG_ALPHA, 256);
					write_reg(REG_JUMP_LIMIT, 1); write_reg(REG_X_SPAN, 4095);
					write_reg(REG_Y_SPAN, 1);
				end
				2: begin
					write_reg(REG_MIN_HOLD, 16'hffff); write_reg(REG_PRESS_GAP, 16'hffff);
					write_reg(REG_LIFT_HOLD, 16'hffff); write_reg(REG_ALPHA, 0);
					write_reg(REG_JUMP_LIMIT, 1023); write_reg(REG_X_SPAN, 0);
					write_reg(REG_Y_SPAN, 0);
				end
				3: begin
					write_reg(REG_MIN_HOLD, 5); write_reg(REG_PRESS_GAP, 10);
					write_reg(REG_LIFT_HOLD, 8); write_reg(REG_ALPHA, 511);
					write_reg(REG_JUMP_LIMIT, 0); write_reg(REG_X_SPAN, 800);
					write_reg(REG_Y_SPAN, 480);
				end
				default: begin
					write_reg(REG_MIN_HOLD, $urandom_range(0, 200));
					write_reg(REG_PRESS_GAP, $urandom_range(0, 300));
					write_reg(REG_LIFT_HOLD, $urandom_range(0, 200));
					write_reg(REG_ALPHA, $urandom_range(0, 300));
					write_reg(REG_JUMP_LIMIT, $urandom_range(0, 1023));
					write_reg(REG_X_SPAN, $urandom_range(1, 4095));
					write_reg(REG_Y_SPAN, $urandom_range(1, 4095));
				end
			endcase
			if (ph == 4) long_go = ~long_go;
			random_samples(290);
			wait_drained();
		end

		if (errors == 0) begin
			$display("touch_debounce_smoothing_filter test passed");
		end else begin
			$display("touch_debounce_smoothing_filter test failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/tdsf_pkg.sv
hdl/tdsf_front.sv
hdl/tdsf_back.sv
hdl/touch_debounce_smoothing_filter.sv
tb/tb_touch_debounce_smoothing_filter.sv
